[design/dqd_pkg.sv]
// shared types and codes of the two-queue dispatcher
`default_nettype none
package dqd_pkg;

  localparam int SUM_W   = 48;
  localparam int EVT_W   = 32;
  localparam int LIMIT_W = 5;
  localparam int OUT_ID_W = 16;

  localparam logic [1:0] CMD_ENQ_A = 2'd0;
  localparam logic [1:0] CMD_ENQ_B = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_STAT  = 2'd3;

  localparam logic [1:0] ACT_IDLE = 2'd0;
  localparam logic [1:0] ACT_A    = 2'd1;
  localparam logic [1:0] ACT_B    = 2'd2;

  localparam logic [3:0] STAT_REQ_A  = 4'd0;
  localparam logic [3:0] STAT_IDLE   = 4'd8;
  localparam logic [3:0] STAT_SUM_A  = 4'd9;
  localparam logic [3:0] STAT_SUM_B  = 4'd10;
  localparam logic [3:0] STAT_SIZE_A = 4'd11;
  localparam logic [3:0] STAT_SIZE_B = 4'd12;

  typedef struct packed {
    logic             req_a;
    logic             req_b;
    logic             acc_a;
    logic             acc_b;
    logic             ref_a;
    logic             ref_b;
    logic             srv_a;
    logic             srv_b;
    logic [1:0]       idle_inc;
    logic [SUM_W-1:0] delta_a;
    logic [SUM_W-1:0] delta_b;
  } stat_upd_t;

  typedef struct packed {
    logic [SUM_W-1:0]    stat_value;
    logic [OUT_ID_W-1:0] c_item;
    logic [1:0]          c_action;
    logic [OUT_ID_W-1:0] b_item;
    logic [1:0]          b_action;
    logic [OUT_ID_W-1:0] a_item;
    logic [1:0]          a_action;
    logic                accepted;
  } result_t;

endpackage
`default_nettype wire

[design/two_queue_three_server_dispatcher.sv]
// top level: two bounded request queues dispatched to three servers
// enqueue and statistic read: result register loaded at the accept edge if the output is
// free, else held until it is; 1 per cycle while the output takes them; tick: each queue
// memory has one registered read port; server c needs a second read after servers a and b
// reset: synchronous, clears pointers, counts, counters and wait sums, sets the limit to 16
// queue memories are not cleared; only entries inside the live count are ever used
`default_nettype none
module two_queue_three_server_dispatcher #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [87:0]  s_tdata,  // item_id, arrival_time, now_time, stat_select, zero pad
  input  wire logic [1:0]   s_tuser,  // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [103:0] m_tdata,  // accepted, server_a_action, server_a_item,
                                      // server_b_action, server_b_item, server_c_action,
                                      // server_c_item, stat_value, zero pad
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [4:0]   cfg_data
);
  import dqd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ENT_W = ID_BITS + TIME_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TICK1 = 2'd1;
  localparam logic [1:0] S_TICK2 = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]           state, state_next;
  logic [PTR_W-1:0]     head_a, head_a_next, tail_a, tail_a_next;
  logic [PTR_W-1:0]     head_b, head_b_next, tail_b, tail_b_next;
  logic [CNT_W-1:0]     count_a, count_a_next, count_b, count_b_next;
  logic [LIMIT_W-1:0]   enq_cap;
  logic [TIME_BITS-1:0] now_t;
  logic [1:0]           c_sel, c_sel_next;
  result_t              res, res_next, hold, fin_res, out_data;

  logic [1:0]           cmd;
  logic [15:0]          in_id;
  logic [31:0]          in_arrival;
  logic [31:0]          in_now;
  logic [3:0]           in_sel;
  logic                 accept, out_free, finish, load_out;
  logic                 admit_a, admit_b;
  logic                 we_a, we_b, re_a, re_b;
  logic [PTR_W-1:0]     raddr_a, raddr_b;
  logic [ENT_W-1:0]     wentry, rd_a, rd_b;
  logic [CNT_W-1:0]     cnt_a_after, cnt_b_after;
  logic [SUM_W-1:0]     stat_value;
  stat_upd_t            upd;

  assign cmd        = s_tuser;
  assign in_id      = s_tdata[15:0];
  assign in_arrival = s_tdata[47:16];
  assign in_now     = s_tdata[79:48];
  assign in_sel     = s_tdata[83:80];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_data};

  assign admit_a = (CMP_W'(count_a) < CMP_W'(enq_cap)) &&
                   (CMP_W'(count_a) < CMP_W'(QUEUE_DEPTH));
  assign admit_b = (CMP_W'(count_b) < CMP_W'(enq_cap)) &&
                   (CMP_W'(count_b) < CMP_W'(QUEUE_DEPTH));
  assign wentry  = {TIME_BITS'(in_arrival), ID_BITS'(in_id)};

  assign cnt_a_after = count_a - CNT_W'(count_a != '0);
  assign cnt_b_after = count_b - CNT_W'(count_b != '0);

  always_comb begin
    state_next   = state;
    head_a_next  = head_a;
    tail_a_next  = tail_a;
    count_a_next = count_a;
    head_b_next  = head_b;
    tail_b_next  = tail_b;
    count_b_next = count_b;
    c_sel_next   = c_sel;
    res_next     = res;
    fin_res      = '0;
    finish       = 1'b0;
    upd          = '0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    re_a         = 1'b0;
    re_b         = 1'b0;
    raddr_a      = ptr_inc(head_a);
    raddr_b      = ptr_inc(head_b);
    upd.delta_a  = SUM_W'(now_t) - SUM_W'(rd_a[ENT_W-1:ID_BITS]);
    upd.delta_b  = SUM_W'(now_t) - SUM_W'(rd_b[ENT_W-1:ID_BITS]);

    unique case (state)
      S_IDLE: begin
        raddr_a = head_a;
        raddr_b = head_b;
        if (accept) begin
          unique case (cmd)
            CMD_ENQ_A: begin
              upd.req_a = 1'b1;
              finish    = 1'b1;
              if (admit_a) begin
                we_a             = 1'b1;
                tail_a_next      = ptr_inc(tail_a);
                count_a_next     = count_a + 1'b1;
                upd.acc_a        = 1'b1;
                fin_res.accepted = 1'b1;
              end else begin
                upd.ref_a = 1'b1;
              end
            end
            CMD_ENQ_B: begin
              upd.req_b = 1'b1;
              finish    = 1'b1;
              if (admit_b) begin
                we_b             = 1'b1;
                tail_b_next      = ptr_inc(tail_b);
                count_b_next     = count_b + 1'b1;
                upd.acc_b        = 1'b1;
                fin_res.accepted = 1'b1;
              end else begin
                upd.ref_b = 1'b1;
              end
            end
            CMD_TICK: begin
              re_a       = 1'b1;
              re_b       = 1'b1;
              res_next   = '0;
              state_next = S_TICK1;
            end
            CMD_STAT: begin
              fin_res.stat_value = stat_value;
              finish             = 1'b1;
            end
          endcase
        end
      end
      S_TICK1: begin
        if (count_a != '0) begin
          res_next.a_action = ACT_A;
          res_next.a_item   = OUT_ID_W'(rd_a[ID_BITS-1:0]);
          upd.srv_a         = 1'b1;
          head_a_next       = ptr_inc(head_a);
          count_a_next      = cnt_a_after;
        end
        if (count_b != '0) begin
          res_next.b_action = ACT_B;
          res_next.b_item   = OUT_ID_W'(rd_b[ID_BITS-1:0]);
          upd.srv_b         = 1'b1;
          head_b_next       = ptr_inc(head_b);
          count_b_next      = cnt_b_after;
        end
        upd.idle_inc = 2'(count_a == '0) + 2'(count_b == '0);
        priority if (cnt_a_after != '0) begin
          c_sel_next = ACT_A;
          re_a       = 1'b1;
        end else if (cnt_b_after != '0) begin
          c_sel_next = ACT_B;
          re_b       = 1'b1;
        end else begin
          c_sel_next = ACT_IDLE;
        end
        state_next = S_TICK2;
      end
      S_TICK2: begin
        fin_res = res;
        finish  = 1'b1;
        priority if (c_sel == ACT_A) begin
          fin_res.c_action = ACT_A;
          fin_res.c_item   = OUT_ID_W'(rd_a[ID_BITS-1:0]);
          upd.srv_a        = 1'b1;
          head_a_next      = ptr_inc(head_a);
          count_a_next     = cnt_a_after;
        end else if (c_sel == ACT_B) begin
          fin_res.c_action = ACT_B;
          fin_res.c_item   = OUT_ID_W'(rd_b[ID_BITS-1:0]);
          upd.srv_b        = 1'b1;
          head_b_next      = ptr_inc(head_b);
          count_b_next     = cnt_b_after;
        end else begin
          upd.idle_inc = 2'd1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase

    if (finish) begin
      state_next = out_free ? S_IDLE : S_FIN;
    end
  end

  assign load_out = out_free && (finish || state == S_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head_a   <= '0;
      tail_a   <= '0;
      count_a  <= '0;
      head_b   <= '0;
      tail_b   <= '0;
      count_b  <= '0;
      c_sel    <= ACT_IDLE;
      enq_cap  <= LIMIT_W'(16);
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      head_a  <= head_a_next;
      tail_a  <= tail_a_next;
      count_a <= count_a_next;
      head_b  <= head_b_next;
      tail_b  <= tail_b_next;
      count_b <= count_b_next;
      c_sel   <= c_sel_next;
      if (cfg_valid && cfg_ready) begin
        enq_cap <= cfg_data;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept && cmd == CMD_TICK) begin
      now_t <= TIME_BITS'(in_now);
    end
    if (finish && !out_free) begin
      hold <= fin_res;
    end
    if (load_out) begin
      out_data <= finish ? fin_res : hold;
    end
  end

  dqd_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (tail_a),
    .wdata (wentry),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  dqd_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (tail_b),
    .wdata (wentry),
    .re    (re_b),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  dqd_stats #(
    .CNT_W (CNT_W)
  ) u_stats (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .stat_sel   (in_sel),
    .count_a    (count_a),
    .count_b    (count_b),
    .stat_value (stat_value)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(count_a) <= CMP_W'(QUEUE_DEPTH)) && (CMP_W'(count_b) <= CMP_W'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_ENQ_A && admit_a |=> count_a == $past(count_a) + 1'b1)
    else $error("admitted enqueue did not grow class a queue");

  a_tick_seq: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_TICK |=> state == S_TICK1 ##1 state == S_TICK2)
    else $error("tick did not walk both read cycles");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> m_tvalid)
    else $error("held result while output register empty");
`endif

endmodule
`default_nettype wire

[design/dqd_ram.sv]
// queue entry memory, one write and one registered read port
`default_nettype none
module dqd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/dqd_stats.sv]
// event counters, wait sums and statistic select
`default_nettype none
module dqd_stats #(
  parameter int CNT_W = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dqd_pkg::stat_upd_t       upd,
  input  wire logic [3:0]               stat_sel,
  input  wire logic [CNT_W-1:0]         count_a,
  input  wire logic [CNT_W-1:0]         count_b,
  output logic      [dqd_pkg::SUM_W-1:0] stat_value
);
  import dqd_pkg::*;

  logic [EVT_W-1:0] ev [9];
  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        ev[i] <= '0;
      end
      sum_a <= '0;
      sum_b <= '0;
    end else begin
      ev[0] <= ev[0] + EVT_W'(upd.req_a);
      ev[1] <= ev[1] + EVT_W'(upd.req_b);
      ev[2] <= ev[2] + EVT_W'(upd.acc_a);
      ev[3] <= ev[3] + EVT_W'(upd.acc_b);
      ev[4] <= ev[4] + EVT_W'(upd.ref_a);
      ev[5] <= ev[5] + EVT_W'(upd.ref_b);
      ev[6] <= ev[6] + EVT_W'(upd.srv_a);
      ev[7] <= ev[7] + EVT_W'(upd.srv_b);
      ev[8] <= ev[8] + EVT_W'(upd.idle_inc);
      if (upd.srv_a) begin
        sum_a <= sum_a + upd.delta_a;
      end
      if (upd.srv_b) begin
        sum_b <= sum_b + upd.delta_b;
      end
    end
  end

  always_comb begin
    priority if (stat_sel <= STAT_IDLE) begin
      stat_value = SUM_W'(ev[stat_sel]);
    end else if (stat_sel == STAT_SUM_A) begin
      stat_value = sum_a;
    end else if (stat_sel == STAT_SUM_B) begin
      stat_value = sum_b;
    end else if (stat_sel == STAT_SIZE_A) begin
      stat_value = SUM_W'(count_a);
    end else if (stat_sel == STAT_SIZE_B) begin
      stat_value = SUM_W'(count_b);
    end else begin
      stat_value = '0;
    end
  end

endmodule
`default_nettype wire

[dv/two_queue_three_server_dispatcher_test.sv]
// testbench of the two-queue dispatcher: directed and random beats against a queue scoreboard
module two_queue_three_server_dispatcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dqd_pkg::*;

  localparam int DEPTH = 16;
  localparam int EV_REQ = 0;
  localparam int EV_ACC = 2;
  localparam int EV_REF = 4;
  localparam int EV_SRV = 6;
  localparam int EV_IDLE = 8;
  localparam int CLS_A = 0;
  localparam int CLS_B = 1;
  localparam int MAX_SHOWN = 10;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 218;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [87:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [4:0] cfg_data;
  logic [8:0] stall_cyc = '0;
  logic [31:0] clock_now = '0;

  class dispatch_scoreboard;
    logic [15:0] ids[2][DEPTH];
    logic [31:0] arrivals[2][DEPTH];
    int unsigned head[2];
    int unsigned fill[2];
    logic [31:0] events[9];
    logic [47:0] wait_sum[2];
    logic [4:0] limit;
    result_t expected[$];
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_bad;

    function new();
      for (int c = 0; c < 2; c++) begin
        head[c] = 0;
        fill[c] = 0;
        wait_sum[c] = '0;
      end
      for (int k = 0; k < 9; k++) events[k] = '0;
      limit = 5'd16;
      n_items = 0;
      n_results = 0;
      n_bad = 0;
    endfunction

    function void set_limit(logic [4:0] v);
      limit = v;
    endfunction

    function logic [1:0] pop(int cls, logic [31:0] now, output logic [15:0] item);
      int unsigned h;
      item = '0;
      if (fill[cls] == 0) return ACT_IDLE;
      h = head[cls];
      item = ids[cls][h];
      wait_sum[cls] = wait_sum[cls] + {16'd0, now} - {16'd0, arrivals[cls][h]};
      events[EV_SRV + cls] += 1;
      head[cls] = (h + 1) % DEPTH;
      fill[cls]--;
      return (cls == CLS_B) ? ACT_B : ACT_A;
    endfunction

    function void note_input(logic [1:0] cmd, logic [15:0] id, logic [31:0] arrival,
                             logic [31:0] now, logic [3:0] sel);
      result_t r;
      int cls;
      int unsigned cap;
      logic [15:0] item;
      r = '0;
      n_items++;
      cap = (limit > DEPTH) ? DEPTH : limit;
      case (cmd)
        CMD_ENQ_A, CMD_ENQ_B: begin
          cls = (cmd == CMD_ENQ_B) ? CLS_B : CLS_A;
          events[EV_REQ + cls] += 1;
          if (fill[cls] < cap) begin
            ids[cls][(head[cls] + fill[cls]) % DEPTH] = id;
            arrivals[cls][(head[cls] + fill[cls]) % DEPTH] = arrival;
            fill[cls]++;
            events[EV_ACC + cls] += 1;
            r.accepted = 1'b1;
          end else begin
            events[EV_REF + cls] += 1;
          end
        end
        CMD_TICK: begin
          r.a_action = pop(CLS_A, now, item);
          r.a_item = item;
          r.b_action = pop(CLS_B, now, item);
          r.b_item = item;
          // server c prefers class a while it still has entries
          r.c_action = pop((fill[CLS_A] != 0) ? CLS_A : CLS_B, now, item);
          r.c_item = item;
          if (r.a_action == ACT_IDLE) events[EV_IDLE] += 1;
          if (r.b_action == ACT_IDLE) events[EV_IDLE] += 1;
          if (r.c_action == ACT_IDLE) events[EV_IDLE] += 1;
        end
        default: begin
          if (sel <= STAT_IDLE) r.stat_value = {16'd0, events[sel]};
          else if (sel == STAT_SUM_A) r.stat_value = wait_sum[CLS_A];
          else if (sel == STAT_SUM_B) r.stat_value = wait_sum[CLS_B];
          else if (sel == STAT_SIZE_A) r.stat_value = 48'(fill[CLS_A]);
          else if (sel == STAT_SIZE_B) r.stat_value = 48'(fill[CLS_B]);
        end
      endcase
      expected.push_back(r);
    endfunction

    function void compare(string field, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("result %0d %s: expected %h, got %h", n_results, field, want, got);
      end
    endfunction

    function void check_result(logic [103:0] beat);
      result_t got;
      result_t want;
      got = result_t'(beat[102:0]);
      n_results++;
      if (expected.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN) $display("result %0d arrived with none pending: %h",
                                         n_results, beat);
        return;
      end
      want = expected.pop_front();
      compare("accepted", 48'(want.accepted), 48'(got.accepted));
      compare("server_a_action", 48'(want.a_action), 48'(got.a_action));
      compare("server_a_item", 48'(want.a_item), 48'(got.a_item));
      compare("server_b_action", 48'(want.b_action), 48'(got.b_action));
      compare("server_b_item", 48'(want.b_item), 48'(got.b_item));
      compare("server_c_action", 48'(want.c_action), 48'(got.c_action));
      compare("server_c_item", 48'(want.c_item), 48'(got.c_item));
      compare("stat_value", want.stat_value, got.stat_value);
    endfunction
  endclass

  dispatch_scoreboard sb;

  two_queue_three_server_dispatcher dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: stall pattern cycles through four modes
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 9'd1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    case (stall_cyc[8:7])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_cyc[3:0] < 4'd4);
    endcase
  end

  task automatic send_beat(logic [1:0] cmd, logic [15:0] id, logic [31:0] arrival,
                           logic [31:0] now, logic [3:0] sel);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'd0, sel, now, arrival, id};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, id, arrival, now, sel);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain();
    // wait out any tick in flight, leave the block fully quiet
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic run_random(int n, int enq_pct);
    int burst;
    int r;
    logic [1:0] cmd;
    logic [15:0] id;
    logic [31:0] arrival;
    logic [31:0] now;
    logic [3:0] sel;
    burst = $urandom_range(1, 40);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) cmd = $urandom_range(0, 1) ? CMD_ENQ_B : CMD_ENQ_A;
      else if (r < enq_pct + (100 - enq_pct) * 3 / 4) cmd = CMD_TICK;
      else cmd = CMD_STAT;
      clock_now = clock_now + 32'($urandom_range(0, 50));
      id = 16'($urandom);
      arrival = ($urandom_range(0, 7) == 0) ? $urandom
                                             : clock_now - 32'($urandom_range(0, 20));
      now = ($urandom_range(0, 7) == 0) ? $urandom : clock_now;
      sel = 4'($urandom_range(0, 15));
      send_beat(cmd, id, arrival, now, sel);
      burst--;
      if (k == n / 2) drain();
      if (burst <= 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    logic [4:0] limits[PHASES];
    int enq_mix[PHASES];
    sb = new();
    limits = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd17, 5'd16, 5'd2};
    enq_mix = '{70, 50, 45, 65, 55, 80, 40, 50};
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= CMD_ENQ_A;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_beat(CMD_ENQ_A, 16'h0000, 32'h0000_0000, 32'h0, STAT_REQ_A);
    send_beat(CMD_ENQ_A, 16'hffff, 32'hffff_ffff, 32'h0, STAT_REQ_A);
    send_beat(CMD_ENQ_A, 16'h1234, 32'd100, 32'h0, STAT_REQ_A);
    send_beat(CMD_ENQ_B, 16'habcd, 32'h0000_0000, 32'h0, STAT_REQ_A);
    send_beat(CMD_STAT, 16'h0, 32'h0, 32'h0, STAT_SIZE_A);
    // c takes the second class a entry, whose arrival lies after now
    send_beat(CMD_TICK, 16'h0, 32'h0, 32'd10, STAT_REQ_A);
    send_beat(CMD_TICK, 16'h0, 32'h0, 32'hffff_ffff, STAT_REQ_A);
    send_beat(CMD_TICK, 16'h0, 32'h0, 32'h0, STAT_REQ_A);
    send_beat(CMD_ENQ_B, 16'h0001, 32'hffff_ffff, 32'h0, STAT_REQ_A);
    send_beat(CMD_ENQ_B, 16'h0002, 32'h0000_0000, 32'h0, STAT_REQ_A);
    // class a empty: c falls back to class b
    send_beat(CMD_TICK, 16'h0, 32'h0, 32'd5, STAT_REQ_A);
    for (int s = 0; s < 16; s++) send_beat(CMD_STAT, 16'($urandom), $urandom, $urandom, 4'(s));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) write_limit(limits[p]);
      run_random(PHASE_BEATS, enq_mix[p]);
    end
    drain();
    repeat (8) @(posedge clk);

    $display("%0d beats, %0d results checked over %0d queue limits from 0 to 31",
             sb.n_items, sb.n_results, PHASES);
    $display("enqueues accepted %0d refused %0d, pops %0d, idle server slots %0d",
             sb.events[EV_ACC] + sb.events[EV_ACC + 1], sb.events[EV_REF] + sb.events[EV_REF + 1],
             sb.events[EV_SRV] + sb.events[EV_SRV + 1], sb.events[EV_IDLE]);
    if (sb.n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.n_bad);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timed out with %0d results pending", sb.expected.size());
    $display("FAILURE");
    $finish;
  end

endmodule
